[rtl/plr_pkg.sv]
// shared types and constants of the printer link packet receiver
`default_nettype none
package plr_pkg;

	localparam logic [7:0] MAGIC_A = 8'h88;
	localparam logic [7:0] MAGIC_B = 8'h33;

	localparam logic [7:0] CMD_INIT  = 8'h01;
	localparam logic [7:0] CMD_PRINT = 8'h02;
	localparam logic [7:0] CMD_DATA  = 8'h04;
	localparam logic [7:0] CMD_STAT  = 8'h0F;

	localparam logic [7:0] ST_PKT  = 8'h10;
	localparam logic [7:0] ST_FULL = 8'h04;
	localparam logic [7:0] ST_BUSY = 8'h02;
	localparam logic [7:0] ST_SUM  = 8'h01;

	localparam logic [7:0] DEVICE_ID_RESET = 8'h81;

	typedef enum logic [10:0] {
		PH_IDLE = 11'b000_0000_0001,
		PH_MAG2 = 11'b000_0000_0010,
		PH_CMD  = 11'b000_0000_0100,
		PH_COMP = 11'b000_0000_1000,
		PH_LEN1 = 11'b000_0001_0000,
		PH_LEN2 = 11'b000_0010_0000,
		PH_DATA = 11'b000_0100_0000,
		PH_CHK1 = 11'b000_1000_0000,
		PH_CHK2 = 11'b001_0000_0000,
		PH_STAT = 11'b010_0000_0000,
		PH_DONE = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       store_full;
	} item_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       write_data;
		logic       write_setting;
		logic       clear_store;
		logic       open_packet;
		logic       drop_packet;
		logic       begin_print;
	} result_t;

endpackage
`default_nettype wire

[rtl/plr_if.sv]
// handshake channels of the printer link packet receiver
`default_nettype none
interface plr_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       store_full;

	modport source (output valid, output req_type, output data_byte, output store_full,
		input ready);
	modport sink (input valid, input req_type, input data_byte, input store_full,
		output ready);
endinterface

interface plr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] reply_byte;
	logic       write_data;
	logic       write_setting;
	logic       clear_store;
	logic       open_packet;
	logic       drop_packet;
	logic       begin_print;

	modport source (output valid, output reply_byte, output write_data,
		output write_setting, output clear_store, output open_packet,
		output drop_packet, output begin_print, input ready);
	modport sink (input valid, input reply_byte, input write_data,
		input write_setting, input clear_store, input open_packet,
		input drop_packet, input begin_print, output ready);
endinterface

interface plr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/plr_parser.sv]
// packet parser state and per-byte next-state and result logic
`default_nettype none
module plr_parser
	import plr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire item_t   item,
	input  wire logic [7:0] device_id,
	output result_t      result
);

	phase_t      phase_q, phase_n;
	logic [7:0]  cmd_q, cmd_n;
	logic [7:0]  status_q, status_n;
	logic [15:0] left_q, left_n;
	logic [15:0] sum_q, sum_n;
	logic        add;
	logic        bad;
	logic [15:0] len_full;
	logic [7:0]  b;

	assign b        = item.data_byte;
	assign len_full = {b, left_q[7:0]};

	always_comb begin
		phase_n  = phase_q;
		cmd_n    = cmd_q;
		status_n = status_q;
		left_n   = left_q;
		sum_n    = sum_q;
		result   = '0;
		add      = 1'b1;
		bad      = 1'b0;
		if (item.req_type) begin
			// print finished event
			status_n = status_q & ~ST_BUSY;
			add      = 1'b0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (b != MAGIC_A) begin
						bad = 1'b1;
					end else begin
						sum_n   = '0;
						phase_n = PH_MAG2;
						add     = 1'b0;
					end
				end
				PH_MAG2: begin
					if (b != MAGIC_B) begin
						bad = 1'b1;
					end else begin
						phase_n = PH_CMD;
						add     = 1'b0;
					end
				end
				PH_CMD: begin
					cmd_n   = b;
					phase_n = PH_COMP;
					if (b == CMD_INIT) begin
						result.clear_store = 1'b1;
						result.open_packet = 1'b1;
						status_n           = '0;
					end else if (b == CMD_DATA) begin
						result.open_packet = 1'b1;
					end else if (b != CMD_PRINT && b != CMD_STAT) begin
						bad = 1'b1;
					end
				end
				PH_COMP: begin
					if (b != 8'h00) begin
						bad = 1'b1;
					end else begin
						phase_n = PH_LEN1;
					end
				end
				PH_LEN1: begin
					left_n  = {8'h00, b};
					phase_n = PH_LEN2;
				end
				PH_LEN2: begin
					left_n  = len_full;
					phase_n = (len_full != 16'h0000) ? PH_DATA : PH_CHK1;
				end
				PH_DATA: begin
					if (cmd_q == CMD_DATA) begin
						result.write_data = 1'b1;
						if (item.store_full) begin
							status_n = status_q | ST_FULL;
						end
					end else if (cmd_q == CMD_PRINT) begin
						result.write_setting = 1'b1;
					end
					left_n = left_q - 16'd1;
					if (left_q == 16'd1) begin
						phase_n = PH_CHK1;
					end
				end
				PH_CHK1: begin
					sum_n   = sum_q ^ {8'h00, b};
					phase_n = PH_CHK2;
					add     = 1'b0;
				end
				PH_CHK2: begin
					sum_n             = sum_q ^ {b, 8'h00};
					phase_n           = PH_STAT;
					result.reply_byte = device_id;
					add               = 1'b0;
				end
				PH_STAT: begin
					if (sum_q == 16'h0000) begin
						status_n = status_q & ~ST_SUM;
					end else begin
						status_n           = status_q | ST_SUM;
						result.drop_packet = 1'b1;
					end
					if (cmd_q == CMD_PRINT) begin
						status_n           = status_n | ST_BUSY;
						result.begin_print = 1'b1;
					end
					result.reply_byte = status_n;
					phase_n           = PH_DONE;
					add               = 1'b0;
				end
				PH_DONE: begin
					phase_n = PH_IDLE;
				end
				default: begin
					bad = 1'b1;
				end
			endcase
			if (bad) begin
				// parser reset
				result            = '0;
				result.clear_store = 1'b1;
				phase_n           = PH_IDLE;
				cmd_n             = '0;
				status_n          = status_q | ST_PKT;
				left_n            = '0;
				sum_n             = '0;
				add               = 1'b0;
			end
		end
		if (add) begin
			sum_n = sum_n + {8'h00, b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cmd_q    <= '0;
			status_q <= '0;
			left_q   <= '0;
			sum_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			cmd_q    <= cmd_n;
			status_q <= status_n;
			left_q   <= left_n;
			sum_q    <= sum_n;
		end
	end

endmodule
`default_nettype wire

[rtl/printer_link_packet_receiver_top.sv]
// top level: input register, packet parser, result register
// a request transaction is held in the input register; its result is then captured
// in the result register, from which its result transaction is offered
// throughput: one request transaction per cycle unless the result stalls; input
//   and result registers hold one item each; a stalled result backs up after two
// reset: parser idle, status and counters zero, device id 0x81, both registers empty
`default_nettype none
module printer_link_packet_receiver_top
	import plr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	plr_req_if.sink  req,
	plr_rsp_if.source rsp,
	plr_cfg_if.sink  cfg
);

	logic       valid_s1;
	item_t      item_s1;
	logic       rsp_valid_q;
	result_t    rsp_q;
	logic [7:0] device_id_q;
	logic       advance;
	result_t    result;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RESET;
		end else if (cfg.valid) begin
			device_id_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{req_type: req.req_type, data_byte: req.data_byte,
				store_full: req.store_full};
		end
	end

	plr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.device_id (device_id_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.reply_byte    = rsp_q.reply_byte;
	assign rsp.write_data    = rsp_q.write_data;
	assign rsp.write_setting = rsp_q.write_setting;
	assign rsp.clear_store   = rsp_q.clear_store;
	assign rsp.open_packet   = rsp_q.open_packet;
	assign rsp.drop_packet   = rsp_q.drop_packet;
	assign rsp.begin_print   = rsp_q.begin_print;

	// a print start always reports busy in the status reply
	a_print_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.begin_print |-> rsp.reply_byte[1])
		else $error("begin_print without busy status");

	// a dropped packet always reports a checksum error
	a_drop_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.drop_packet |-> rsp.reply_byte[0])
		else $error("drop_packet without checksum error status");

	// image data and setting strobes are exclusive
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.write_data && rsp.write_setting))
		else $error("write_data and write_setting together");

	// an input register stalled by the output must not advance
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp.ready |=> valid_s1 && $stable(item_s1))
		else $error("input register lost an item under stall");

endmodule
`default_nettype wire
